@@ src/idru_pkg.sv @@
// Shared types and constants for the integer divide / remainder unit.
// No dependencies; every other file of the unit imports this package.
package idru_pkg;

	localparam int IDRU_XLEN       = 32;
	localparam int IDRU_DATA_WIDTH = 32;

	typedef enum logic [1:0] {
		FUNC_DIV  = 2'd0,
		FUNC_DIVU = 2'd1,
		FUNC_REM  = 2'd2,
		FUNC_REMU = 2'd3
	} func_t;

	// Control that travels with each request down the pipeline.
	typedef struct packed {
		logic want_rem;
		logic neg_q;
		logic neg_r;
	} ctl_t;

endpackage

@@ src/idru_req_if.sv @@
// Request channel of the divide unit: valid/ready handshake with operands.
// Depends on idru_pkg.
interface idru_req_if import idru_pkg::*; ();
	logic                 valid;
	logic                 ready;
	func_t                func;
	logic [IDRU_XLEN-1:0] dividend;
	logic [IDRU_XLEN-1:0] divisor;

	modport source (output valid, func, dividend, divisor, input ready);
	modport sink   (input valid, func, dividend, divisor, output ready);
endinterface

@@ src/idru_rsp_if.sv @@
// Response channel of the divide unit: valid/ready handshake with the result.
// Depends on idru_pkg.
interface idru_rsp_if import idru_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [IDRU_XLEN-1:0] result;

	modport source (output valid, result, input ready);
	modport sink   (input valid, result, output ready);
endinterface

@@ src/idru_pre.sv @@
// Front stage of the divider: decodes the operation and takes operand magnitudes.
// Depends on idru_pkg.
module idru_pre import idru_pkg::*; #(
	parameter int W = IDRU_DATA_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  func_t        func,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] num_s1,
	output logic [W-1:0] den_s1,
	output ctl_t         ctl_s1
);

	logic         v_s1;
	logic         is_signed;
	logic         want_rem;
	logic         b_zero;
	logic         a_neg;
	logic         b_neg;
	logic [W-1:0] ua;
	logic [W-1:0] ub;

	always_comb begin
		case (func)
			FUNC_DIV: begin
				is_signed = 1'b1;
				want_rem  = 1'b0;
			end
			FUNC_DIVU: begin
				is_signed = 1'b0;
				want_rem  = 1'b0;
			end
			FUNC_REM: begin
				is_signed = 1'b1;
				want_rem  = 1'b1;
			end
			FUNC_REMU: begin
				is_signed = 1'b0;
				want_rem  = 1'b1;
			end
			default: begin
				is_signed = 1'b0;
				want_rem  = 1'b0;
			end
		endcase
	end

	// A zero divisor is run as an unsigned division: the long division then
	// yields all ones and the dividend, which is what the ISA asks for. The
	// signed overflow case falls out of the magnitude path without help.
	assign b_zero = (b == '0);
	assign a_neg  = is_signed & a[W-1] & ~b_zero;
	assign b_neg  = is_signed & b[W-1] & ~b_zero;
	assign ua     = a_neg ? (~a + W'(1)) : a;
	assign ub     = b_neg ? (~b + W'(1)) : b;

	assign in_ready  = ~v_s1 | out_ready;
	assign out_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			num_s1          <= ua;
			den_s1          <= ub;
			ctl_s1.want_rem <= want_rem;
			ctl_s1.neg_q    <= a_neg ^ b_neg;
			ctl_s1.neg_r    <= a_neg;
		end
	end

`ifndef SYNTH
	a_neg_needs_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && ctl_s1.neg_r |-> den_s1 != '0)
		else $error("negative dividend flagged with a zero divisor");
`endif

endmodule

@@ src/idru_div_stage.sv @@
// One restoring-division step: shifts in one dividend bit, retires one quotient bit.
// Depends on idru_pkg.
module idru_div_stage import idru_pkg::*; #(
	parameter int W = IDRU_DATA_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] r_i,
	input  logic [W-1:0] nq_i,
	input  logic [W-1:0] den_i,
	input  ctl_t         ctl_i,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] r_sk,
	output logic [W-1:0] nq_sk,
	output logic [W-1:0] den_sk,
	output ctl_t         ctl_sk
);

	// nq holds the unused dividend bits at the top and the quotient bits
	// found so far at the bottom; after the last step it is the quotient.
	logic         v_sk;
	logic         carry;
	logic [W-1:0] shifted;
	logic [W:0]   diff;
	logic         take;

	assign carry   = r_i[W-1];
	assign shifted = {r_i[W-2:0], nq_i[W-1]};
	assign diff    = {carry, shifted} - {1'b0, den_i};
	assign take    = carry | ~diff[W];

	assign in_ready  = ~v_sk | out_ready;
	assign out_valid = v_sk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sk <= 1'b0;
		end else if (in_ready) begin
			v_sk <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			r_sk   <= take ? diff[W-1:0] : shifted;
			nq_sk  <= {nq_i[W-2:0], take};
			den_sk <= den_i;
			ctl_sk <= ctl_i;
		end
	end

`ifndef SYNTH
	rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		v_sk && den_sk != '0 |-> r_sk < den_sk)
		else $error("partial remainder not below the divisor");

	stalled_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_sk && !out_ready |=> v_sk && $stable(r_sk) && $stable(nq_sk))
		else $error("stalled division stage changed its contents");
`endif

endmodule

@@ src/idru_post.sv @@
// Final stage of the divider: applies signs and picks quotient or remainder.
// Depends on idru_pkg.
module idru_post import idru_pkg::*; #(
	parameter int W = IDRU_DATA_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] rem_i,
	input  logic [W-1:0] quo_i,
	input  ctl_t         ctl_i,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] res_s1
);

	logic         v_s1;
	logic [W-1:0] pick;
	logic         neg;
	logic [W-1:0] res;

	assign pick = ctl_i.want_rem ? rem_i : quo_i;
	assign neg  = ctl_i.want_rem ? ctl_i.neg_r : ctl_i.neg_q;
	assign res  = neg ? (~pick + W'(1)) : pick;

	assign in_ready  = ~v_s1 | out_ready;
	assign out_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_s1 <= res;
		end
	end

endmodule

@@ src/integer_divide_remainder_unit.sv @@
// Integer divide / remainder unit, RISC-V M semantics (DIV, DIVU, REM, REMU).
// A request on req carries func, dividend and divisor; for each request one
// result word leaves on rsp, in request order. Both channels use valid/ready
// and move a request or result at a clock edge where both are high.
// The datapath is a pipeline of DATA_WIDTH + 2 register stages: an operand
// stage (decode, magnitudes), one restoring-division stage per quotient bit,
// and a sign/select stage that holds the result. A new request can enter
// every cycle unless a stalled rsp has filled the pipeline.
// Each stage holds its item until the next stage has room, so a stalled rsp
// fills the pipeline from the back and only then drops req.ready; empty
// stages are filled even while a result waits. Nothing is lost or repeated.
// Divide by zero returns all ones (quotient) or the dividend (remainder);
// the most negative value divided by minus one returns the dividend or zero.
// Reset (arst_n low) empties every stage; there is no other state.
// Depends on idru_pkg, idru_req_if, idru_rsp_if, idru_pre, idru_div_stage,
// and idru_post.
module integer_divide_remainder_unit import idru_pkg::*; #(
	parameter int DATA_WIDTH = IDRU_DATA_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	idru_req_if.sink          req,
	idru_rsp_if.source        rsp
);

	localparam int W = DATA_WIDTH;

	logic [W-1:0] a_w;
	logic [W-1:0] b_w;
	logic [W-1:0] res_w;

	logic         v_w   [0:W];
	logic         rdy_w [0:W];
	logic [W-1:0] r_w   [0:W];
	logic [W-1:0] nq_w  [0:W];
	logic [W-1:0] den_w [0:W];
	ctl_t         ctl_w [0:W];

	generate
		if (W > IDRU_XLEN) begin : g_wide
			assign a_w        = {{(W-IDRU_XLEN){1'b0}}, req.dividend};
			assign b_w        = {{(W-IDRU_XLEN){1'b0}}, req.divisor};
			assign rsp.result = res_w[IDRU_XLEN-1:0];
		end else if (W == IDRU_XLEN) begin : g_same
			assign a_w        = req.dividend;
			assign b_w        = req.divisor;
			assign rsp.result = res_w;
		end else begin : g_narrow
			assign a_w        = req.dividend[W-1:0];
			assign b_w        = req.divisor[W-1:0];
			assign rsp.result = {{(IDRU_XLEN-W){1'b0}}, res_w};
		end
	endgenerate

	idru_pre #(.W(W)) u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.func      (req.func),
		.a         (a_w),
		.b         (b_w),
		.out_valid (v_w[0]),
		.out_ready (rdy_w[0]),
		.num_s1    (nq_w[0]),
		.den_s1    (den_w[0]),
		.ctl_s1    (ctl_w[0])
	);

	// The partial remainder starts at zero for every request.
	assign r_w[0] = '0;

	generate
		for (genvar k = 0; k < W; k++) begin : g_step
			idru_div_stage #(.W(W)) u_step (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (v_w[k]),
				.in_ready  (rdy_w[k]),
				.r_i       (r_w[k]),
				.nq_i      (nq_w[k]),
				.den_i     (den_w[k]),
				.ctl_i     (ctl_w[k]),
				.out_valid (v_w[k+1]),
				.out_ready (rdy_w[k+1]),
				.r_sk      (r_w[k+1]),
				.nq_sk     (nq_w[k+1]),
				.den_sk    (den_w[k+1]),
				.ctl_sk    (ctl_w[k+1])
			);
		end
	endgenerate

	idru_post #(.W(W)) u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_w[W]),
		.in_ready  (rdy_w[W]),
		.rem_i     (r_w[W]),
		.quo_i     (nq_w[W]),
		.ctl_i     (ctl_w[W]),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.res_s1    (res_w)
	);

`ifndef SYNTH
	empty_output_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp.valid |-> req.ready)
		else $error("request refused while the output stage is empty");

	final_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		v_w[W] && den_w[W] != '0 |-> r_w[W] < den_w[W])
		else $error("final remainder not below the divisor");
`endif

endmodule
